// ===== hdl/dwt_pkg.sv =====
package dwt_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxRes  = 5;
  localparam int unsigned CntW    = 3;
  localparam int unsigned SumW    = 10;

  localparam logic [ByteW-1:0] CharNul    = 8'h00;
  localparam logic [ByteW-1:0] CharSpace  = 8'h20;
  localparam logic [ByteW-1:0] CharDot    = 8'h2E;
  localparam logic [ByteW-1:0] CharZero   = 8'h30;
  localparam logic [ByteW-1:0] CharBslash = 8'h5C;

  // Expansion of one input byte: up to five characters, drained one per beat.
  // The done and bad flags belong to the last character of the run.
  typedef struct packed {
    logic [MaxRes-1:0][ByteW-1:0] chars;
    logic [CntW-1:0]              cnt;
    logic                         done;
    logic                         bad;
  } run_t;

endpackage

// ===== hdl/dwt_in_if.sv =====
interface dwt_in_if;
  import dwt_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] name_byte;
  logic             new_name;

  modport source (output valid, output name_byte, output new_name, input ready);
  modport sink   (input valid, input name_byte, input new_name, output ready);
endinterface

// ===== hdl/dwt_out_if.sv =====
interface dwt_out_if;
  import dwt_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_char;
  logic             name_done;
  logic             bad_name;
  logic             last_of_run;

  modport source (output valid, output out_char, output name_done, output bad_name,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_char, input name_done, input bad_name,
                  input last_of_run, output ready);
  modport mon    (input valid, input ready, input out_char, input name_done,
                  input bad_name, input last_of_run);
endinterface

// ===== hdl/dns_wire_name_to_text.sv =====
// With the result register free, a byte's first character is offered in the cycle after
// the byte's beat; otherwise it waits until the run drains. One result character per cycle
// while the output is ready; a run holds the output until its last character is taken.
// Input takes one beat per cycle while each byte yields at most one character and the
// output is ready; a one-entry holding register absorbs a further byte while a run drains.
// Reset: parser halted until a byte flagged new_name, run and holding registers empty.
module dns_wire_name_to_text #(
  parameter int unsigned MAX_LABEL_LEN = 63,
  parameter int unsigned MAX_NAME_LEN  = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  dwt_in_if.sink    in_i,
  dwt_out_if.source out_o
);
  import dwt_pkg::*;

  localparam int unsigned RemW = $clog2(MAX_LABEL_LEN + 1);
  localparam int unsigned OffW = $clog2(MAX_NAME_LEN);

  logic [RemW-1:0] rem_q, rem_d;
  logic [OffW-1:0] off_q, off_d;
  logic            start_q, start_d;
  logic            halted_q, halted_d;

  run_t            hold_q, hold_d;
  logic            hold_vld_q, hold_vld_d;
  run_t            run_q, run_d;
  logic            run_vld_q, run_vld_d;
  logic [CntW-1:0] idx_q, idx_d;

  run_t            item;
  logic            acc;
  logic            acc_nz;
  logic            take;
  logic            last;
  logic            run_free;

  // Parser: works on the state as seen after a possible new_name restart.
  always_comb begin
    logic [RemW-1:0] eff_rem;
    logic [OffW-1:0] eff_off;
    logic            eff_start;
    logic            eff_halt;
    logic [ByteW-1:0] b;
    logic [CntW-1:0] n;
    logic [ByteW-1:0] tens;
    logic [ByteW-1:0] ones;
    logic [SumW-1:0] sum;

    b         = in_i.name_byte;
    eff_rem   = in_i.new_name ? '0 : rem_q;
    eff_off   = in_i.new_name ? '0 : off_q;
    eff_start = in_i.new_name ? 1'b1 : start_q;
    eff_halt  = in_i.new_name ? 1'b0 : halted_q;

    rem_d    = eff_rem;
    off_d    = eff_off;
    start_d  = eff_start;
    halted_d = eff_halt;

    item = '0;
    n    = '0;
    sum  = SumW'(eff_off) + SumW'(1) + SumW'(b);

    if (b >= 8'd30) begin
      tens = 8'd3;
      ones = b - 8'd30;
    end else if (b >= 8'd20) begin
      tens = 8'd2;
      ones = b - 8'd20;
    end else if (b >= 8'd10) begin
      tens = 8'd1;
      ones = b - 8'd10;
    end else begin
      tens = 8'd0;
      ones = b;
    end

    if (!eff_halt) begin
      if (eff_rem == '0) begin
        if (b == CharNul) begin
          if (eff_start) begin
            item.chars[n] = CharDot;
            n = n + 3'd1;
          end
          item.chars[n] = CharNul;
          n = n + 3'd1;
          item.done = 1'b1;
          halted_d  = 1'b1;
        end else if (sum >= SumW'(MAX_NAME_LEN) || b > ByteW'(MAX_LABEL_LEN)) begin
          item.chars[n] = CharNul;
          n = n + 3'd1;
          item.bad  = 1'b1;
          halted_d  = 1'b1;
        end else begin
          rem_d   = b[RemW-1:0];
          off_d   = eff_off + OffW'(1);
          start_d = 1'b0;
        end
      end else begin
        off_d = eff_off + OffW'(1);
        rem_d = eff_rem - RemW'(1);
        if (b == CharDot || b == CharBslash) begin
          item.chars[n] = CharBslash;
          n = n + 3'd1;
          item.chars[n] = b;
          n = n + 3'd1;
        end else if (b <= CharSpace) begin
          // Control bytes and space are written as three decimal digits; hundreds is zero.
          item.chars[n] = CharBslash;
          n = n + 3'd1;
          item.chars[n] = CharZero;
          n = n + 3'd1;
          item.chars[n] = CharZero + tens;
          n = n + 3'd1;
          item.chars[n] = CharZero + ones;
          n = n + 3'd1;
        end else begin
          item.chars[n] = b;
          n = n + 3'd1;
        end
        if (eff_rem == RemW'(1)) begin
          item.chars[n] = CharDot;
          n = n + 3'd1;
        end
      end
    end
    item.cnt = n;
  end

  assign in_i.ready = !hold_vld_q;
  assign acc        = in_i.valid && in_i.ready;
  assign acc_nz     = acc && (item.cnt != '0);

  assign last     = (idx_q == run_q.cnt - CntW'(1));
  assign take     = out_o.valid && out_o.ready;
  assign run_free = !run_vld_q || (take && last);

  assign out_o.valid       = run_vld_q;
  assign out_o.out_char    = run_q.chars[idx_q];
  assign out_o.last_of_run = last;
  assign out_o.name_done   = run_q.done && last;
  assign out_o.bad_name    = run_q.bad && last;

  // Drain and refill of the run register; the holding register takes a byte that
  // arrives while the current run is still being read out.
  always_comb begin
    run_d      = run_q;
    run_vld_d  = run_vld_q;
    idx_d      = idx_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;

    if (run_free) begin
      idx_d = '0;
      if (hold_vld_q) begin
        run_d      = hold_q;
        run_vld_d  = 1'b1;
        hold_vld_d = 1'b0;
      end else begin
        run_d     = item;
        run_vld_d = acc_nz;
      end
    end else begin
      if (take) begin
        idx_d = idx_q + CntW'(1);
      end
      if (acc_nz) begin
        hold_d     = item;
        hold_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q      <= '0;
      off_q      <= '0;
      start_q    <= 1'b1;
      halted_q   <= 1'b1;
      hold_vld_q <= 1'b0;
      run_vld_q  <= 1'b0;
      idx_q      <= '0;
    end else begin
      if (acc) begin
        rem_q    <= rem_d;
        off_q    <= off_d;
        start_q  <= start_d;
        halted_q <= halted_d;
      end
      hold_vld_q <= hold_vld_d;
      run_vld_q  <= run_vld_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    run_q  <= run_d;
  end

endmodule

// ===== hdl/dwt_checker.sv =====
module dwt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      valid_i,
  input logic                      ready_i,
  input logic [dwt_pkg::ByteW-1:0] out_char_i,
  input logic                      name_done_i,
  input logic                      bad_name_i,
  input logic                      last_of_run_i
);
  import dwt_pkg::*;

  // A waiting beat holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(out_char_i) && $stable(last_of_run_i))
    else $error("output beat changed while stalled");

  // The terminator closes its run and carries a NUL.
  a_done_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && name_done_i |-> out_char_i == CharNul && last_of_run_i && !bad_name_i)
    else $error("name_done on a non-terminating character");

  // The error result stands alone.
  a_bad_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && bad_name_i |-> out_char_i == CharNul && last_of_run_i)
    else $error("bad_name result malformed");

  // Content NUL bytes are always escaped, so a bare NUL is a terminator or an error.
  a_nul_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && out_char_i == CharNul |-> name_done_i || bad_name_i)
    else $error("unflagged NUL character");

endmodule

bind dns_wire_name_to_text dwt_checker u_dwt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (out_o.valid),
  .ready_i       (out_o.ready),
  .out_char_i    (out_o.out_char),
  .name_done_i   (out_o.name_done),
  .bad_name_i    (out_o.bad_name),
  .last_of_run_i (out_o.last_of_run)
);

// ===== verif/dns_wire_name_to_text_tb.sv =====
`timescale 1ns / 1ps

module dns_wire_name_to_text_tb;
  import dwt_pkg::*;

  localparam int unsigned MaxLabel   = 63;
  localparam int unsigned MaxName    = 256;
  localparam int unsigned RandBytes  = 500;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned DrainWait  = 10;
  localparam int unsigned MaxReports = 50;

  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             done;
    logic             bad;
    logic             last;
  } text_beat_t;

  // Tracks the parser state of the block and keeps the characters it still owes.
  class text_scoreboard;
    logic [5:0]   label_left;
    logic [8:0]   wire_off;
    bit           at_start;
    bit           halted;
    text_beat_t   run_text[$];
    text_beat_t   pending_text[$];
    int unsigned  errors;
    int unsigned  bytes_parsed;
    int unsigned  chars_seen;
    int unsigned  names_done;
    int unsigned  names_bad;

    function new();
      label_left = '0;
      wire_off   = '0;
      at_start   = 1'b1;
      halted     = 1'b1;
    endfunction

    function void add_char(logic [ByteW-1:0] ch, logic done, logic bad);
      text_beat_t b;
      b.ch     = ch;
      b.done   = done;
      b.bad    = bad;
      b.last   = 1'b0;
      run_text = {run_text, b};
    endfunction

    function void note_wire_byte(logic [ByteW-1:0] b, logic nn);
      run_text = {};
      if (nn) begin
        label_left = '0;
        wire_off   = '0;
        at_start   = 1'b1;
        halted     = 1'b0;
      end
      if (halted) return;
      bytes_parsed++;
      if (label_left == 0) begin
        if (b == CharNul) begin
          if (at_start) add_char(CharDot, 1'b0, 1'b0);
          add_char(CharNul, 1'b1, 1'b0);
          halted = 1'b1;
          names_done++;
        end else if (int'(wire_off) + 1 + int'(b) >= MaxName || b > MaxLabel) begin
          add_char(CharNul, 1'b0, 1'b1);
          halted = 1'b1;
          names_bad++;
        end else begin
          label_left = b[5:0];
          wire_off   = wire_off + 9'd1;
          at_start   = 1'b0;
        end
      end else begin
        wire_off   = wire_off + 9'd1;
        label_left = label_left - 6'd1;
        if (b == CharDot || b == CharBslash) begin
          add_char(CharBslash, 1'b0, 1'b0);
          add_char(b, 1'b0, 1'b0);
        end else if (b <= CharSpace) begin
          // Control characters and space are written as three decimal digits.
          add_char(CharBslash, 1'b0, 1'b0);
          add_char(CharZero + b / 8'd100, 1'b0, 1'b0);
          add_char(CharZero + (b / 8'd10) % 8'd10, 1'b0, 1'b0);
          add_char(CharZero + b % 8'd10, 1'b0, 1'b0);
        end else begin
          add_char(b, 1'b0, 1'b0);
        end
        if (label_left == 0) add_char(CharDot, 1'b0, 1'b0);
      end
      if (run_text.size() > 0) run_text[run_text.size()-1].last = 1'b1;
      pending_text = {pending_text, run_text};
    endfunction

    function void check_text_char(text_beat_t got);
      text_beat_t want;
      chars_seen++;
      if (pending_text.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected beat: expected none, got %02h/%0b/%0b/%0b",
                   $time, got.ch, got.done, got.bad, got.last);
        return;
      end
      want = pending_text.pop_front();
      if (got !== want) begin
        errors++;
        // Fields are shown as char/done/bad/last.
        if (errors <= MaxReports)
          $display("%0t: mismatch: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                   $time, want.ch, want.done, want.bad, want.last,
                   got.ch, got.done, got.bad, got.last);
        else if (errors == MaxReports + 1)
          $display("%0t: further mismatches are counted but not shown", $time);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  dwt_in_if  in_bus ();
  dwt_out_if out_bus ();

  dns_wire_name_to_text #(
    .MAX_LABEL_LEN (MaxLabel),
    .MAX_NAME_LEN  (MaxName)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  text_scoreboard sb = new();
  int unsigned    items_sent;
  int unsigned    quiet_cycles;
  bit             hold_done;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_bus.valid && in_bus.ready)
      sb.note_wire_byte(in_bus.name_byte, in_bus.new_name);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      sb.check_text_char('{out_bus.out_char, out_bus.name_done, out_bus.bad_name,
                           out_bus.last_of_run});
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("%0t: no beat for %0d cycles", $time, StallLimit);
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Text side: random stalls, one long hold-off to back the block up, and a
  // stretch where every beat is taken at once.
  initial begin
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && sb.chars_seen >= 60) begin
        out_bus.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (sb.chars_seen >= 200 && sb.chars_seen < 450) begin
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= 37);
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b, input logic nn);
    @(negedge clk_i);
    if (!(items_sent >= 100 && items_sent < 300)) begin
      while ($urandom_range(0, 99) < 37) begin
        in_bus.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_bus.valid     <= 1'b1;
    in_bus.name_byte <= b;
    in_bus.new_name  <= nn;
    do @(posedge clk_i); while (!in_bus.ready);
    items_sent++;
  endtask

  function automatic logic [ByteW-1:0] pick_content();
    case ($urandom_range(0, 9))
      0:       return CharDot;
      1:       return CharBslash;
      2, 3:    return ByteW'($urandom_range(0, 32));
      4:       return 8'hFF;
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_label(input int unsigned len, input logic nn);
    send_byte(ByteW'(len), nn);
    repeat (len) send_byte(pick_content(), 1'b0);
  endtask

  // Labels of up to 63 bytes until the name would pass its size limit. With
  // fill set the last label is trimmed so that the name just fits.
  task automatic send_long_name(input bit fill);
    int unsigned off;
    int unsigned len;
    off = 0;
    forever begin
      len = $urandom_range(40, MaxLabel);
      if (fill) begin
        if (off + 1 + len > MaxName - 1) len = MaxName - 2 - off;
        if (len < 1 || off + 2 > MaxName - 1) break;
      end
      if (off + 1 + len >= MaxName) begin
        send_byte(ByteW'(len), off == 0);
        send_byte(pick_content(), 1'b0);
        return;
      end
      send_label(len, off == 0);
      off += 1 + len;
    end
    send_byte(CharNul, off == 0);
  endtask

  task automatic send_short_name(input bit abandon);
    int unsigned labels;
    int unsigned len;
    logic        first;
    labels = $urandom_range(0, 4);
    first  = 1'b1;
    for (int unsigned i = 0; i < labels; i++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MaxLabel) : $urandom_range(1, 8);
      if (abandon && i == labels - 1) begin
        send_byte(ByteW'(len), first);
        repeat ($urandom_range(0, len - 1)) send_byte(pick_content(), 1'b0);
        return;
      end
      send_label(len, first);
      first = 1'b0;
    end
    send_byte(CharNul, first);
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.name_byte = '0;
    in_bus.new_name  = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Bytes before any new name are dropped.
    send_byte(8'hFF, 1'b0);
    send_byte(CharNul, 1'b0);
    // Root name.
    send_byte(CharNul, 1'b1);
    // Every escape form, the extremes of a content byte, then the end of name.
    send_byte(8'd5, 1'b1);
    send_byte(CharDot, 1'b0);
    send_byte(CharBslash, 1'b0);
    send_byte(CharNul, 1'b0);
    send_byte(CharSpace, 1'b0);
    send_byte(CharSpace + 8'd1, 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CharNul, 1'b0);
    // Label one past the limit, followed by a byte that must be ignored.
    send_byte(8'd64, 1'b1);
    send_byte(8'd3, 1'b0);
    // A name abandoned part-way through a label.
    send_byte(8'd3, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(8'd2, 1'b1);
    send_byte(8'h7A, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(CharNul, 1'b0);
    // Largest length byte.
    send_byte(8'hFF, 1'b1);

    send_long_name(1'b0);
    send_long_name(1'b1);
    while (sb.bytes_parsed < RandBytes) begin
      case ($urandom_range(0, 9))
        0: send_short_name(1'b1);
        1: begin
          send_byte(ByteW'($urandom_range(MaxLabel + 1, 255)), 1'b1);
          repeat ($urandom_range(1, 3)) send_byte(ByteW'($urandom_range(0, 255)), 1'b0);
        end
        2: repeat ($urandom_range(1, 6))
             send_byte(ByteW'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        default: send_short_name(1'b0);
      endcase
    end

    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (sb.pending_text.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d wire bytes (%0d parsed) and checked %0d text characters.",
             items_sent, sb.bytes_parsed, sb.chars_seen);
    $display("Names completed: %0d, names rejected: %0d, mismatches: %0d.",
             sb.names_done, sb.names_bad, sb.errors);
    if (sb.errors == 0 && sb.pending_text.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
